@@ hw/rtl/ilcp_pkg.sv @@
// Shared types, character codes and decode helpers for the line character parser.
// Used by ilcp_classify, ini_line_char_parser and ilcp_checker. No dependencies.
`default_nettype none

package ilcp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_W  = 8'h77;

  typedef enum logic [2:0] {
    LS_BEGIN   = 3'd0,
    LS_KEY     = 3'd1,
    LS_VALUE   = 3'd2,
    LS_COMMENT = 3'd3,
    LS_SECOPEN = 3'd4,
    LS_SECDONE = 3'd5,
    LS_EMPTY   = 3'd6
  } line_state_e;

  typedef enum logic [2:0] {
    CL_CONSUMED = 3'd0,
    CL_KEY      = 3'd1,
    CL_VALUE    = 3'd2,
    CL_COMMENT  = 3'd3,
    CL_EOL      = 3'd4,
    CL_EOD      = 3'd5,
    CL_ERROR    = 3'd6
  } char_class_e;

  typedef struct packed {
    line_state_e line_state;
    logic        escape_pending;
    logic        error_latched;
  } parse_state_t;

  typedef struct packed {
    char_class_e char_class;
    logic [7:0]  out_byte;
  } result_t;

  localparam parse_state_t StateReset = '{line_state: LS_BEGIN, escape_pending: 1'b0,
                                          error_latched: 1'b0};

  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] d;
    case (c)
      CH_ZERO: d = CH_NUL;
      CH_LC_N: d = CH_NL;
      CH_LC_B: d = CH_BSL;
      CH_LC_W: d = CH_SPACE;
      CH_LC_E: d = CH_EQ;
      CH_LC_S: d = CH_SEMI;
      CH_LC_R: d = CH_HASH;
      default: d = c;
    endcase
    return d;
  endfunction

  function automatic char_class_e part_class(input line_state_e ls);
    char_class_e cl;
    case (ls)
      LS_KEY:     cl = CL_KEY;
      LS_VALUE:   cl = CL_VALUE;
      LS_COMMENT: cl = CL_COMMENT;
      default:    cl = CL_CONSUMED;
    endcase
    return cl;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ini_line_char_parser.sv @@
// Top level of the configuration line character parser: state registers,
// result register and skid stage around ilcp_classify. Depends on ilcp_pkg.
//
// Usage: one text byte enters per item on the input channel (in_valid_i,
// in_ready_o, in_byte_i) and exactly one result item leaves on the output
// channel (out_valid_o, out_ready_i, char_class_o, out_byte_o) for each.
// The line state, escape bit and error latch are updated in the cycle an
// item is accepted, so the next byte is classified in the following cycle.
// An accepted item's result goes to the result register when the output
// is free and to the skid stage otherwise; throughput is one item per
// cycle while the skid stage is empty. Classification is combinational.
// A stalled receiver holds the result register; one further item is taken
// into the skid stage, and in_ready_o drops only while the skid stage is
// full. in_ready_o therefore never depends on out_ready_i in the same cycle.
// Reset clears the line state to begin of line, the escape and error bits,
// and both valid flags, so result items still held at reset are dropped.
`default_nettype none

module ini_line_char_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] char_class_o,
  output logic [7:0] out_byte_o
);
  import ilcp_pkg::*;

  parse_state_t state_q, state_d;
  result_t      result_d;
  result_t      out_q, skid_q;
  logic         out_valid_q, skid_valid_q;
  logic         in_fire, out_free;

  ilcp_classify u_classify (
    .in_byte_i (in_byte_i),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StateReset;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= in_fire;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_fire) begin
          skid_q <= result_d;
        end
      end else if (in_fire) begin
        out_q <= result_d;
      end
    end else if (in_fire) begin
      skid_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_class_o = out_q.char_class;
  assign out_byte_o   = out_q.out_byte;

endmodule

`default_nettype wire

@@ hw/rtl/ilcp_classify.sv @@
// Combinational classification of one text byte against the current line state.
// Depends on ilcp_pkg for the state, result types and escape decoding.
`default_nettype none

module ilcp_classify (
  input  logic [7:0]            in_byte_i,
  input  ilcp_pkg::parse_state_t state_i,
  output ilcp_pkg::parse_state_t state_o,
  output ilcp_pkg::result_t      result_o
);
  import ilcp_pkg::*;

  char_class_e part;

  assign part = part_class(state_i.line_state);

  always_comb begin
    state_o  = state_i;
    result_o = '{char_class: CL_CONSUMED, out_byte: 8'h00};
    if (in_byte_i == CH_NUL) begin
      state_o             = StateReset;
      result_o.char_class = CL_EOD;
    end else if (in_byte_i == CH_NL) begin
      state_o             = StateReset;
      result_o.char_class = CL_EOL;
    end else if (state_i.error_latched) begin
      result_o.char_class = CL_CONSUMED;
    end else if (state_i.escape_pending) begin
      state_o.escape_pending = 1'b0;
      result_o.char_class    = part;
      if (part != CL_CONSUMED) begin
        result_o.out_byte = decode_escape(in_byte_i);
      end
    end else if (state_i.line_state == LS_BEGIN) begin
      if (in_byte_i == CH_LBRK) begin
        state_o.line_state = LS_SECOPEN;
      end else if (in_byte_i == CH_HASH) begin
        state_o.line_state    = LS_EMPTY;
        state_o.error_latched = 1'b1;
        result_o.char_class   = CL_ERROR;
      end else begin
        state_o.line_state  = LS_KEY;
        result_o.char_class = CL_KEY;
        result_o.out_byte   = in_byte_i;
      end
    end else if (state_i.line_state == LS_KEY && in_byte_i == CH_EQ) begin
      state_o.line_state = LS_VALUE;
    end else if (state_i.line_state == LS_VALUE && in_byte_i == CH_SEMI) begin
      state_o.line_state = LS_COMMENT;
    end else if (state_i.line_state == LS_SECOPEN && in_byte_i == CH_RBRK) begin
      state_o.line_state = LS_SECDONE;
    end else if (in_byte_i == CH_BSL) begin
      state_o.escape_pending = 1'b1;
    end else if (part != CL_CONSUMED) begin
      result_o.char_class = part;
      result_o.out_byte   = in_byte_i;
    end else begin
      result_o.char_class   = CL_ERROR;
      state_o.error_latched = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ilcp_checker.sv @@
// Port-level checks for ini_line_char_parser, attached to it by bind.
// Depends on ilcp_pkg for the class codes.
`default_nettype none

module ilcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] char_class_o,
  input logic [7:0] out_byte_o
);
  import ilcp_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_byte_i);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(char_class_o)
      && $stable(out_byte_o))
    else $error("Stalled result item changed or was dropped.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(char_class_o == CL_KEY || char_class_o == CL_VALUE
      || char_class_o == CL_COMMENT) |-> out_byte_o == 8'h00)
    else $error("Byte reported for a class that carries none.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> char_class_o != 3'd7)
    else $error("Undefined character class reported.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !$past(out_ready_i && out_valid_o && !in_valid_i))
    else $error("Input held off while the result register could drain.");

endmodule

bind ini_line_char_parser ilcp_checker u_ilcp_checker (.*);

`default_nettype wire
